FILE: src/imuyaw_pkg.sv
// Shared types and constants for the IMU yaw integrator with gyro bias calibration.
// Holds the channel payload structs, the internal command and unit interfaces and
// the fixed scaling constants. No dependencies.
package imuyaw_pkg;

    localparam int PERIOD_W    = 20;
    localparam int DIVISOR_W   = 17;
    localparam int ACCUM_W     = 64;
    localparam int YAW_W       = 48;
    localparam int CAL_SUM_W   = 32;
    localparam int SQ_W        = 32;
    localparam int DIV_BITS    = 4;
    localparam int Q_DEPTH     = 2;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 20'd200000;
    localparam logic [15:0]          ACC_SCALE    = 16'd40181;
    localparam logic [DIVISOR_W-1:0] YAW_DIV      = 17'd131000;

    localparam logic signed [ACCUM_W-1:0] ACCUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACCUM_W-1:0] ACCUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [ACCUM_W-1:0] YAW_MAX   = 64'sd140737488355327;
    localparam logic signed [ACCUM_W-1:0] YAW_MIN   = -64'sd140737488355327;

    localparam logic [1:0] REQ_MEAS = 2'd0;
    localparam logic [1:0] REQ_CAL  = 2'd1;
    localparam logic [1:0] REQ_ZERO = 2'd2;

    typedef enum logic [1:0] {
        K_MEAS,
        K_CAL,
        K_ZERO,
        K_NONE
    } t_kind;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_BIAS,
        BS_YAW,
        BS_YAW_WAIT,
        BS_OUT
    } t_back_state;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [15:0]  accel_x;
        logic signed [15:0]  accel_y;
        logic signed [15:0]  accel_z;
        logic signed [15:0]  gyro_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]       accel_x_ms2;
        logic signed [15:0]       accel_y_ms2;
        logic signed [15:0]       accel_z_ms2;
        logic [15:0]              accel_magnitude;
        logic signed [YAW_W-1:0]  yaw_millideg;
        logic signed [15:0]       gyro_bias;
        logic                     cal_done;
    } t_out_item;

    typedef struct packed {
        t_kind               kind;
        logic signed [15:0]  accel_x;
        logic signed [15:0]  accel_y;
        logic signed [15:0]  accel_z;
        logic signed [15:0]  gyro_z;
    } t_cmd;

    typedef struct packed {
        logic             start;
        logic [SQ_W-1:0]  value;
    } t_sqrt_req;

    typedef struct packed {
        logic         done;
        logic [15:0]  root;
    } t_sqrt_rsp;

    typedef struct packed {
        logic                         start;
        logic signed [ACCUM_W-1:0]    dividend;
        logic [DIVISOR_W-1:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                         done;
        logic signed [ACCUM_W-1:0]    quotient;
    } t_div_rsp;

endpackage

FILE: src/imuyaw_front.sv
// Front end: accepts input beats, decodes the request code and hands commands on.
// Depends on imuyaw_pkg.
module imuyaw_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  imuyaw_pkg::t_in_item   i_in_data,
    output logic                   o_push,
    input  logic                   i_q_ready,
    output imuyaw_pkg::t_cmd       o_cmd
);
    import imuyaw_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;

    assign o_in_ready = !r_valid || i_q_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.accel_x = i_in_data.accel_x;
        n_cmd.accel_y = i_in_data.accel_y;
        n_cmd.accel_z = i_in_data.accel_z;
        n_cmd.gyro_z  = i_in_data.gyro_z;
        case (i_in_data.req_type)
            REQ_MEAS: n_cmd.kind = K_MEAS;
            REQ_CAL:  n_cmd.kind = K_CAL;
            REQ_ZERO: n_cmd.kind = K_ZERO;
            default:  n_cmd.kind = K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: src/imuyaw_queue.sv
// Short command queue between the front end and the back end.
// Depends on imuyaw_pkg for the command type and depth.
module imuyaw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_ready,
    input  imuyaw_pkg::t_cmd   i_data,
    output logic               o_valid,
    input  logic               i_pop,
    output imuyaw_pkg::t_cmd   o_data
);
    import imuyaw_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/imuyaw_sqrt.sv
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// Depends on imuyaw_pkg for the request and response structs.
module imuyaw_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  imuyaw_pkg::t_sqrt_req   i_req,
    output imuyaw_pkg::t_sqrt_rsp   o_rsp
);
    import imuyaw_pkg::*;

    localparam logic [SQ_W-1:0] TOP_BIT = 32'h4000_0000;

    logic              r_busy;
    logic              r_done;
    logic [SQ_W-1:0]   r_n;
    logic [SQ_W-1:0]   r_res;
    logic [SQ_W-1:0]   r_bit;
    logic [SQ_W-1:0]   trial;

    assign trial      = r_res + r_bit;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                // last pair of bits handled this cycle
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n   <= i_req.value;
            r_res <= '0;
            r_bit <= TOP_BIT;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

FILE: src/imuyaw_div.sv
// Signed 64-bit by unsigned 17-bit divider, quotient truncated toward zero.
// Restoring division on the magnitude, DIV_BITS quotient bits per cycle. Depends on imuyaw_pkg.
module imuyaw_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  imuyaw_pkg::t_div_req   i_req,
    output imuyaw_pkg::t_div_rsp   o_rsp
);
    import imuyaw_pkg::*;

    localparam int STEPS = ACCUM_W / DIV_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic                   r_busy;
    logic                   r_done;
    logic                   r_neg;
    logic [ACCUM_W-1:0]     r_mq;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVISOR_W-1:0]   r_div;
    logic [CNT_W-1:0]       r_cnt;
    logic [ACCUM_W-1:0]     n_mq;
    logic [DIVISOR_W-1:0]   n_rem;

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed(r_mq) : $signed(r_mq);

    // shift dividend bits out of the top, quotient bits in at the bottom
    always_comb begin
        logic [DIVISOR_W:0] shifted;
        n_rem = r_rem;
        n_mq  = r_mq;
        for (int j = 0; j < DIV_BITS; j++) begin
            shifted = {n_rem, n_mq[ACCUM_W-1]};
            n_mq    = {n_mq[ACCUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_div}) begin
                n_rem   = DIVISOR_W'(shifted - {1'b0, r_div});
                n_mq[0] = 1'b1;
            end else begin
                n_rem = shifted[DIVISOR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[ACCUM_W-1];
            r_mq  <= i_req.dividend[ACCUM_W-1] ? ACCUM_W'(-i_req.dividend)
                                               : ACCUM_W'(i_req.dividend);
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_mq  <= n_mq;
            r_rem <= n_rem;
        end
    end

endmodule

FILE: src/imuyaw_back.sv
// Back end: runs one command at a time through a shared multiplier, the square
// root unit and the divider, keeps yaw and calibration state and registers results.
// Depends on imuyaw_pkg, imuyaw_sqrt and imuyaw_div.
module imuyaw_back #(
    parameter int CAL_SAMPLES = 200
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [imuyaw_pkg::PERIOD_W-1:0]        i_cfg_wr_data,
    input  logic                                   i_q_valid,
    output logic                                   o_q_pop,
    input  imuyaw_pkg::t_cmd                       i_q_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output imuyaw_pkg::t_out_item                  o_out_data
);
    import imuyaw_pkg::*;

    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int PROD_W  = 39;

    // multiplier sequence; each product is registered and used at the next step
    localparam logic [2:0] STEP_XX     = 3'd0;
    localparam logic [2:0] STEP_YY     = 3'd1;
    localparam logic [2:0] STEP_ZZ     = 3'd2;
    localparam logic [2:0] STEP_SX     = 3'd3;
    localparam logic [2:0] STEP_SY     = 3'd4;
    localparam logic [2:0] STEP_SZ     = 3'd5;
    localparam logic [2:0] STEP_GYRO   = 3'd6;
    localparam logic [2:0] STEP_UPDATE = 3'd7;

    t_back_state                  r_state;
    t_back_state                  n_state;
    logic [2:0]                   r_step;
    t_cmd                         r_cmd;

    logic [PERIOD_W-1:0]          r_period;
    logic signed [15:0]           r_bias;
    logic signed [CAL_SUM_W-1:0]  r_cal_sum;
    logic [CNT_W-1:0]             r_cal_count;
    logic signed [ACCUM_W-1:0]    r_accum;

    logic signed [PROD_W-1:0]     r_prod;
    logic [SQ_W-1:0]              r_sq;
    logic signed [15:0]           r_ax_ms2;
    logic signed [15:0]           r_ay_ms2;
    logic signed [15:0]           r_az_ms2;
    logic [15:0]                  r_mag;
    logic                         r_mag_ok;
    logic signed [YAW_W-1:0]      r_yaw;
    logic                         r_done_flag;
    logic                         r_out_valid;
    t_out_item                    r_out;

    logic signed [17:0]           mul_a;
    logic signed [20:0]           mul_b;
    logic signed [16:0]           gyro_diff;
    logic [CNT_W:0]               cnt_inc;
    logic                         cal_finish;
    logic signed [CAL_SUM_W-1:0]  n_cal_sum;
    logic signed [ACCUM_W-1:0]    delta;
    logic signed [ACCUM_W-1:0]    sum;
    logic signed [ACCUM_W-1:0]    n_accum;
    logic signed [YAW_W-1:0]      n_yaw;
    logic [31:0]                  mag_prod;

    logic                         pop;
    logic                         load_out;
    logic                         state_upd;
    t_sqrt_req                    sqrt_req;
    t_sqrt_rsp                    sqrt_rsp;
    t_div_req                     div_req;
    t_div_rsp                     div_rsp;

    imuyaw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    imuyaw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // calibration and accumulator arithmetic
    assign gyro_diff  = 17'(r_cmd.gyro_z) - 17'(r_bias);
    assign cnt_inc    = (CNT_W + 1)'(r_cal_count) + 1'b1;
    assign cal_finish = (r_cmd.kind == K_CAL) && (cnt_inc >= (CNT_W + 1)'(CAL_SAMPLES));
    assign n_cal_sum  = r_cal_sum + CAL_SUM_W'(r_cmd.gyro_z);
    assign delta      = ACCUM_W'(r_prod);
    assign sum        = r_accum + delta;
    assign mag_prod   = 32'(sqrt_rsp.root) * 32'(ACC_SCALE);

    always_comb begin
        // saturate when both operands share a sign and the sum does not
        if ((r_accum[ACCUM_W-1] == delta[ACCUM_W-1]) &&
            (sum[ACCUM_W-1] != r_accum[ACCUM_W-1])) begin
            n_accum = r_accum[ACCUM_W-1] ? ACCUM_MIN : ACCUM_MAX;
        end else begin
            n_accum = sum;
        end
    end

    always_comb begin
        if (div_rsp.quotient > YAW_MAX) begin
            n_yaw = YAW_W'(YAW_MAX);
        end else if (div_rsp.quotient < YAW_MIN) begin
            n_yaw = YAW_W'(YAW_MIN);
        end else begin
            n_yaw = YAW_W'(div_rsp.quotient);
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_step)
            STEP_XX: begin
                mul_a = 18'(r_cmd.accel_x);
                mul_b = 21'(r_cmd.accel_x);
            end
            STEP_YY: begin
                mul_a = 18'(r_cmd.accel_y);
                mul_b = 21'(r_cmd.accel_y);
            end
            STEP_ZZ: begin
                mul_a = 18'(r_cmd.accel_z);
                mul_b = 21'(r_cmd.accel_z);
            end
            STEP_SX: begin
                mul_a = 18'(r_cmd.accel_x);
                mul_b = 21'(ACC_SCALE);
            end
            STEP_SY: begin
                mul_a = 18'(r_cmd.accel_y);
                mul_b = 21'(ACC_SCALE);
            end
            STEP_SZ: begin
                mul_a = 18'(r_cmd.accel_z);
                mul_b = 21'(ACC_SCALE);
            end
            STEP_GYRO: begin
                mul_a = 18'(gyro_diff);
                mul_b = 21'({1'b0, r_period});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = BS_MUL;
                end
            end
            BS_MUL: begin
                if (r_step == STEP_UPDATE) begin
                    n_state = cal_finish ? BS_BIAS : BS_YAW;
                end
            end
            BS_BIAS: begin
                if (div_rsp.done) begin
                    n_state = BS_YAW;
                end
            end
            BS_YAW: begin
                n_state = BS_YAW_WAIT;
            end
            BS_YAW_WAIT: begin
                if (div_rsp.done) begin
                    n_state = BS_OUT;
                end
            end
            BS_OUT: begin
                if (load_out) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb begin
        pop              = 1'b0;
        load_out         = 1'b0;
        state_upd        = 1'b0;
        sqrt_req.start   = 1'b0;
        sqrt_req.value   = r_sq;
        div_req.start    = 1'b0;
        div_req.dividend = r_accum;
        div_req.divisor  = YAW_DIV;
        case (r_state)
            BS_IDLE: begin
                pop = i_q_valid;
            end
            BS_MUL: begin
                sqrt_req.start = (r_step == STEP_SY);
                if (r_step == STEP_UPDATE) begin
                    state_upd = 1'b1;
                    if (cal_finish) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = ACCUM_W'(n_cal_sum);
                        div_req.divisor  = DIVISOR_W'(CAL_SAMPLES);
                    end
                end
            end
            BS_YAW: begin
                div_req.start = 1'b1;
            end
            BS_OUT: begin
                load_out = r_mag_ok && (!r_out_valid || i_out_ready);
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_mag_ok    <= 1'b0;
            r_period    <= PERIOD_RESET;
            r_bias      <= '0;
            r_cal_sum   <= '0;
            r_cal_count <= '0;
            r_accum     <= '0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_step <= '0;
            end else if (r_state == BS_MUL) begin
                r_step <= r_step + 1'b1;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (pop) begin
                r_mag_ok <= 1'b0;
            end else if (sqrt_rsp.done) begin
                r_mag_ok <= 1'b1;
            end

            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end

            if (state_upd) begin
                case (r_cmd.kind)
                    K_MEAS: begin
                        r_accum <= n_accum;
                    end
                    K_CAL: begin
                        if (cal_finish) begin
                            r_cal_sum   <= '0;
                            r_cal_count <= '0;
                        end else begin
                            r_cal_sum   <= n_cal_sum;
                            r_cal_count <= cnt_inc[CNT_W-1:0];
                        end
                    end
                    K_ZERO: begin
                        r_accum <= '0;
                    end
                    default: begin
                        r_accum <= r_accum;
                    end
                endcase
            end

            if (r_state == BS_BIAS && div_rsp.done) begin
                r_bias <= div_rsp.quotient[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_q_data;
        end
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);

        if (r_state == BS_MUL) begin
            case (r_step)
                STEP_YY:           r_sq <= r_prod[SQ_W-1:0];
                STEP_ZZ, STEP_SX:  r_sq <= r_sq + r_prod[SQ_W-1:0];
                STEP_SY:           r_ax_ms2 <= r_prod[31:16];
                STEP_SZ:           r_ay_ms2 <= r_prod[31:16];
                STEP_GYRO:         r_az_ms2 <= r_prod[31:16];
                STEP_UPDATE:       r_done_flag <= cal_finish;
                default:           r_sq <= r_sq;
            endcase
        end

        if (sqrt_rsp.done) begin
            r_mag <= mag_prod[31:16];
        end

        if (r_state == BS_YAW_WAIT && div_rsp.done) begin
            r_yaw <= n_yaw;
        end

        if (load_out) begin
            r_out.accel_x_ms2     <= r_ax_ms2;
            r_out.accel_y_ms2     <= r_ay_ms2;
            r_out.accel_z_ms2     <= r_az_ms2;
            r_out.accel_magnitude <= r_mag;
            r_out.yaw_millideg    <= r_yaw;
            r_out.gyro_bias       <= r_bias;
            r_out.cal_done        <= r_done_flag;
        end
    end

endmodule

FILE: src/imu_yaw_integrator_with_bias_cal.sv
// IMU yaw integrator with gyro bias calibration. Each input beat returns one
// result beat with scaled X/Y/Z acceleration, the scaled vector magnitude, the yaw
// in millidegrees, the current gyro bias and a calibration-complete flag. Items
// are processed one at a time by the back end: after leaving the command queue an
// item is fetched, takes 8 steps on the shared multiplier, then launches and runs
// the 64-bit divide by 131000 at four quotient bits per cycle, and is loaded into
// the output register; an item that completes a calibration run first runs the
// bias division on the same divider. The square root runs alongside. The input
// register and the two-entry queue take beats until full while the back end is
// busy or a result waits to be taken. The user must write sample_period_us
// through the configuration port while idle; the block itself does not enforce
// this. Depends on imuyaw_pkg, imuyaw_front, imuyaw_queue and imuyaw_back.
module imu_yaw_integrator_with_bias_cal #(
    parameter int CAL_SAMPLES = 200
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [imuyaw_pkg::PERIOD_W-1:0]    i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  imuyaw_pkg::t_in_item               i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output imuyaw_pkg::t_out_item              o_out_data
);
    import imuyaw_pkg::*;

    logic  push;
    logic  q_ready;
    t_cmd  front_cmd;
    logic  q_valid;
    logic  q_pop;
    t_cmd  q_cmd;

    imuyaw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .i_q_ready  (q_ready),
        .o_cmd      (front_cmd)
    );

    imuyaw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_data  (front_cmd),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    imuyaw_back #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_data      (q_cmd),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule
